>>> rtl/csd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_pkg
// shared constants and codes for the column-density sorter
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int unsigned MaxEntriesDef = 65536;
  localparam int unsigned MaxColsDef    = 4096;
  localparam int unsigned RowBitsDef    = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned RowW    = 16;
  localparam int unsigned ColW    = 12;
  localparam int unsigned ValW    = 16;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOAD    = 2'd0,
    OP_FETCH   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  localparam logic [StatusW-1:0] StEntry    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty    = 2'd1;
  localparam logic [StatusW-1:0] StOverflow = 2'd2;

endpackage

>>> rtl/csd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_ram
// single-port-write, single-port-read memory, registered read data
// ----------------------------------------------------------------------------
module csd_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/coo_sort_by_column_density.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sort_by_column_density
// sparse entries grouped by column rank (count descending, lower index first)
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// command  | start, busy        | op_i, row_index_i, col_index_i, entry_value_i
// result   | valid_o (1 cycle)  | out_row_o, out_col_o, out_value_o,
//          |                    | is_last_o, status_o
//
// load: column memory read, then write back
// fetch within a column: entry memory read, result register
// fetch that starts a new column: one column-memory
//   read per cycle while scanning for the next ranked column
// reset and restart run a clearing pass over the column
//   memory; busy stays high throughout
// results cannot be stalled; each shows for one cycle only
// ----------------------------------------------------------------------------
module coo_sort_by_column_density #(
  parameter int unsigned MAX_ENTRIES = csd_pkg::MaxEntriesDef,
  parameter int unsigned MAX_COLS    = csd_pkg::MaxColsDef,
  parameter int unsigned ROW_BITS    = csd_pkg::RowBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [csd_pkg::OpW-1:0]      op_i,
  input  logic [csd_pkg::RowW-1:0]     row_index_i,
  input  logic [csd_pkg::ColW-1:0]     col_index_i,
  input  logic [csd_pkg::ValW-1:0]     entry_value_i,
  output logic                         valid_o,
  output logic [csd_pkg::RowW-1:0]     out_row_o,
  output logic [csd_pkg::ColW-1:0]     out_col_o,
  output logic [csd_pkg::ValW-1:0]     out_value_o,
  output logic                         is_last_o,
  output logic [csd_pkg::StatusW-1:0]  status_o
);

  // widths derived from the capacity
  localparam int unsigned EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EC  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RB  = (ROW_BITS < csd_pkg::RowW) ? ROW_BITS : csd_pkg::RowW;
  localparam int unsigned CMW = EC + 2 * EW;       // {count, head, tail}
  localparam int unsigned EDW = RB + csd_pkg::ValW; // {row, value}

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_LOAD, S_SCAN, S_SCAN_END, S_READ, S_OUT, S_EMPTY
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  scan_addr_q;
  logic [EC-1:0]  entry_count_q, rd_ptr_q;
  logic           sorted_q, ovf_q, have_prev_q;
  logic [EC-1:0]  prev_cnt_q, col_left_q, best_cnt_q;
  logic [CW-1:0]  prev_col_q, cur_col_q, best_col_q, pend_addr_q, ld_col_q;
  logic [EW-1:0]  cur_ptr_q, best_head_q, ld_idx_q;
  logic           pend_q;

  // result registers
  logic                         valid_q, is_last_q;
  logic [csd_pkg::RowW-1:0]     out_row_q;
  logic [csd_pkg::ColW-1:0]     out_col_q;
  logic [csd_pkg::ValW-1:0]     out_value_q;
  logic [csd_pkg::StatusW-1:0]  status_q;

  // memory ports
  logic           cm_we, ent_we, nxt_we;
  logic [CW-1:0]  cm_waddr, cm_raddr;
  logic [CMW-1:0] cm_wdata, cm_rdata;
  logic [EDW-1:0] ent_wdata, ent_rdata;
  logic [EW-1:0]  nxt_waddr, nxt_rdata;

  // column memory fields as read
  logic [EC-1:0]  rd_cnt;
  logic [EW-1:0]  rd_head, rd_tail;
  assign rd_cnt  = cm_rdata[CMW-1 -: EC];
  assign rd_head = cm_rdata[2*EW-1:EW];
  assign rd_tail = cm_rdata[EW-1:0];

  logic accept, col_ok, store_full, last_scan;
  assign accept     = start && !busy;
  assign col_ok     = (32'(col_index_i) < MAX_COLS);
  assign store_full = (entry_count_q == EC'(MAX_ENTRIES));
  assign last_scan  = (scan_addr_q == CW'(MAX_COLS - 1));

  // scan candidate: must rank strictly after the previous column and beat
  // the best so far (ascending scan keeps the lower index on ties)
  logic after_prev, take;
  always_comb begin
    after_prev = !have_prev_q || (rd_cnt < prev_cnt_q) ||
                 ((rd_cnt == prev_cnt_q) && (pend_addr_q > prev_col_q));
    take       = pend_q && after_prev && (rd_cnt > best_cnt_q);
  end

  // memory port steering
  always_comb begin
    cm_we     = 1'b0;
    cm_waddr  = scan_addr_q;
    cm_wdata  = '0;
    if (state_q == S_CLR) begin
      cm_we = 1'b1;
    end else if (state_q == S_LOAD) begin
      cm_we    = 1'b1;
      cm_waddr = ld_col_q;
      cm_wdata = {rd_cnt + EC'(1), (rd_cnt == '0) ? ld_idx_q : rd_head, ld_idx_q};
    end
    cm_raddr  = (state_q == S_IDLE) ? CW'(col_index_i) : scan_addr_q;
    ent_we    = accept && (op_i == csd_pkg::OP_LOAD) && !sorted_q && col_ok && !store_full;
    ent_wdata = {RB'(row_index_i), entry_value_i};
    nxt_we    = (state_q == S_LOAD) && (rd_cnt != '0);
    nxt_waddr = rd_tail;
  end

  csd_ram #(.Depth(MAX_COLS), .Width(CMW), .AddrW(CW)) u_col_mem (
    .clk_i, .we_i(cm_we), .waddr_i(cm_waddr), .wdata_i(cm_wdata),
    .raddr_i(cm_raddr), .rdata_o(cm_rdata)
  );

  csd_ram #(.Depth(MAX_ENTRIES), .Width(EDW), .AddrW(EW)) u_entry_mem (
    .clk_i, .we_i(ent_we), .waddr_i(entry_count_q[EW-1:0]), .wdata_i(ent_wdata),
    .raddr_i(cur_ptr_q), .rdata_o(ent_rdata)
  );

  // per-entry link to the next entry of the same column
  csd_ram #(.Depth(MAX_ENTRIES), .Width(EW), .AddrW(EW)) u_next_mem (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(ld_idx_q),
    .raddr_i(cur_ptr_q), .rdata_o(nxt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      scan_addr_q   <= '0;
      entry_count_q <= '0;
      rd_ptr_q      <= '0;
      sorted_q      <= 1'b0;
      ovf_q         <= 1'b0;
      have_prev_q   <= 1'b0;
      col_left_q    <= '0;
      pend_q        <= 1'b0;
      valid_q       <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          scan_addr_q <= scan_addr_q + CW'(1);
          if (last_scan) begin
            scan_addr_q <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (op_i)
              csd_pkg::OP_LOAD: begin
                if (!sorted_q && col_ok) begin
                  if (store_full) begin
                    ovf_q <= 1'b1;
                  end else begin
                    ld_col_q      <= CW'(col_index_i);
                    ld_idx_q      <= entry_count_q[EW-1:0];
                    entry_count_q <= entry_count_q + EC'(1);
                    state_q       <= S_LOAD;
                  end
                end
              end
              csd_pkg::OP_FETCH: begin
                sorted_q <= 1'b1;
                if (!sorted_q) begin
                  have_prev_q <= 1'b0;
                  col_left_q  <= '0;
                end
                if (rd_ptr_q >= entry_count_q) begin
                  state_q <= S_EMPTY;
                end else if (!sorted_q || col_left_q == '0) begin
                  scan_addr_q <= '0;
                  pend_q      <= 1'b0;
                  best_cnt_q  <= '0;
                  state_q     <= S_SCAN;
                end else begin
                  state_q <= S_READ;
                end
              end
              csd_pkg::OP_RESTART: begin
                entry_count_q <= '0;
                rd_ptr_q      <= '0;
                sorted_q      <= 1'b0;
                ovf_q         <= 1'b0;
                scan_addr_q   <= '0;
                state_q       <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: state_q <= S_IDLE;
        S_SCAN: begin
          if (take) begin
            best_cnt_q  <= rd_cnt;
            best_col_q  <= pend_addr_q;
            best_head_q <= rd_head;
          end
          pend_q      <= 1'b1;
          pend_addr_q <= scan_addr_q;
          scan_addr_q <= scan_addr_q + CW'(1);
          if (last_scan) begin
            state_q <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          // last pending column folds in here
          cur_col_q   <= take ? pend_addr_q : best_col_q;
          cur_ptr_q   <= take ? rd_head : best_head_q;
          col_left_q  <= take ? rd_cnt : best_cnt_q;
          prev_cnt_q  <= take ? rd_cnt : best_cnt_q;
          prev_col_q  <= take ? pend_addr_q : best_col_q;
          have_prev_q <= 1'b1;
          pend_q      <= 1'b0;
          scan_addr_q <= '0;
          state_q     <= S_READ;
        end
        S_READ: state_q <= S_OUT;
        S_OUT: begin
          valid_q     <= 1'b1;
          out_row_q   <= csd_pkg::RowW'(ent_rdata[EDW-1 -: RB]);
          out_col_q   <= csd_pkg::ColW'(cur_col_q);
          out_value_q <= ent_rdata[csd_pkg::ValW-1:0];
          is_last_q   <= ((EC+1)'(rd_ptr_q) + (EC+1)'(1) == (EC+1)'(entry_count_q));
          status_q    <= ovf_q ? csd_pkg::StOverflow : csd_pkg::StEntry;
          rd_ptr_q    <= rd_ptr_q + EC'(1);
          col_left_q  <= col_left_q - EC'(1);
          cur_ptr_q   <= nxt_rdata;
          state_q     <= S_IDLE;
        end
        S_EMPTY: begin
          valid_q     <= 1'b1;
          out_row_q   <= '0;
          out_col_q   <= '0;
          out_value_q <= '0;
          is_last_q   <= 1'b0;
          status_q    <= csd_pkg::StEmpty;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign is_last_o   = is_last_q;
  assign status_o    = status_q;

endmodule

>>> rtl/csd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_checker
// port-level checks on the column-density sorter
// ----------------------------------------------------------------------------
module csd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         busy,
  input logic                         valid_o,
  input logic [csd_pkg::RowW-1:0]     out_row_o,
  input logic                         is_last_o,
  input logic [csd_pkg::StatusW-1:0]  status_o
);

  // a result is a single-cycle pulse
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held");

  // a result only follows a busy cycle
  a_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy)) else $error("result without work");

  // a drained fetch carries a zero row and no last marker
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == csd_pkg::StEmpty) |-> (out_row_o == '0 && !is_last_o))
    else $error("drained result not zero");

  // last marker only on a real entry
  a_last_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_last_o) |-> (status_o == csd_pkg::StEntry ||
                                status_o == csd_pkg::StOverflow))
    else $error("last marker on empty result");

endmodule

bind coo_sort_by_column_density csd_checker u_csd_checker (
  .clk_i, .rst_ni, .busy, .valid_o, .out_row_o, .is_last_o, .status_o
);
